// File: hw/rtl/ikd_pkg.sv
// ----------------------------------------------------------------------------
// ikd_pkg
// Shared types and constants for the descending key index sorter.
// ----------------------------------------------------------------------------
package ikd_pkg;

    localparam int CAPACITY  = 64;
    localparam int KEY_WIDTH = 32;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int IDX_W     = 6;

    typedef struct packed {
        logic signed [31:0] key;
        logic               last;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]   index;
        logic signed [31:0] sorted_key;
        logic               end_of_run;
        logic               overflow;
    } out_item_t;

    typedef struct packed {
        logic [KEY_WIDTH-1:0] key;
        logic [IDX_W-1:0]     index;
    } entry_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_SHIFT  = 2'd2
    } cell_op_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        cell_op_t op;
        entry_t   fresh;
    } cell_ctrl_t;

    // signed compare a >= b via sign-bit flip
    function automatic logic key_ge(input logic [KEY_WIDTH-1:0] a,
                                    input logic [KEY_WIDTH-1:0] b);
        logic [KEY_WIDTH-1:0] sign;
        sign = {1'b1, {(KEY_WIDTH-1){1'b0}}};
        return (a ^ sign) >= (b ^ sign);
    endfunction

endpackage

// File: hw/rtl/ikd_cell.sv
// ----------------------------------------------------------------------------
// ikd_cell
// One slot of the insertion chain: keeps its entry, takes the new key, or
// takes a neighbor's entry.
// ----------------------------------------------------------------------------
module ikd_cell
    import ikd_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  logic       valid,
    input  logic       prev_keep,
    input  entry_t     prev_entry,
    input  entry_t     next_entry,
    output entry_t     entry,
    output logic       keep
);

    entry_t entry_reg;
    entry_t entry_next;

    // ties stay ahead of the new key, so equal keys keep arrival order
    assign keep  = valid && key_ge(entry_reg.key, ctrl.fresh.key);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        case (ctrl.op)
            CELL_INSERT:
            begin
                if (!keep)
                begin
                    entry_next = prev_keep ? ctrl.fresh : prev_entry;
                end
            end
            CELL_SHIFT:
            begin
                entry_next = next_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// File: hw/rtl/index_sort_by_key_descending.sv
// ----------------------------------------------------------------------------
// index_sort_by_key_descending
// Sorts a run of signed keys and returns their arrival indices by
// descending key.
// ----------------------------------------------------------------------------
// Keys are taken one per cycle while busy is low; each is placed in a chain of
// CAPACITY cells in the same cycle, so the chain is always in descending order
// (equal keys in arrival order). The key flagged last starts the output: busy
// rises and the chain shifts toward cell 0 one entry per cycle, returning the
// stored keys as an unbroken run of strobed results, the last one flagged
// end_of_run, after which busy drops. Results cannot be held off: the receiver
// must take one every strobe cycle. Keys beyond CAPACITY are dropped and every
// result of that run shows overflow.
// ----------------------------------------------------------------------------
module index_sort_by_key_descending
    import ikd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  in_item_t  item,
    output logic      busy,
    output logic      strobe,
    output out_item_t result
);

    typedef enum logic [1:0] {
        ST_FILL  = 2'b01,
        ST_DRAIN = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  fill_count_reg, fill_count_next;
    logic              overflow_reg, overflow_next;

    cell_ctrl_t        ctrl;
    entry_t            cell_entry [CAPACITY];
    logic [CAPACITY-1:0] cell_keep;
    logic [CAPACITY-1:0] cell_valid;

    logic accept;
    logic full;

    assign accept = start && (state_reg == ST_FILL);
    assign full   = (fill_count_reg == CNT_W'(CAPACITY));

    always_comb
    begin
        state_next       = state_reg;
        fill_count_next  = fill_count_reg;
        overflow_next    = overflow_reg;
        ctrl.op          = CELL_HOLD;
        ctrl.fresh.key   = KEY_WIDTH'(unsigned'(item.key));
        ctrl.fresh.index = IDX_W'(fill_count_reg);
        unique case (state_reg)
            ST_FILL:
            begin
                if (accept)
                begin
                    if (full)
                    begin
                        overflow_next = 1'b1;
                    end
                    else
                    begin
                        ctrl.op         = CELL_INSERT;
                        fill_count_next = fill_count_reg + CNT_W'(1);
                    end
                    if (item.last)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                ctrl.op         = CELL_SHIFT;
                fill_count_next = fill_count_reg - CNT_W'(1);
                if (fill_count_reg == CNT_W'(1))
                begin
                    state_next    = ST_FILL;
                    overflow_next = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_FILL;
            fill_count_reg <= '0;
            overflow_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_count_reg <= fill_count_next;
            overflow_reg   <= overflow_next;
        end
    end

    // the chain
    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            entry_t prev_e;
            entry_t next_e;
            logic   prev_k;

            assign cell_valid[i] = (CNT_W'(i) < fill_count_reg);

            if (i == 0)
            begin : g_head
                assign prev_e = ctrl.fresh;
                assign prev_k = 1'b0;
            end
            else
            begin : g_body
                assign prev_e = cell_entry[i-1];
                assign prev_k = cell_keep[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_tail
                assign next_e = cell_entry[i];
            end
            else
            begin : g_mid
                assign next_e = cell_entry[i+1];
            end

            ikd_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .valid      (cell_valid[i]),
                .prev_keep  (prev_k),
                .prev_entry (prev_e),
                .next_entry (next_e),
                .entry      (cell_entry[i]),
                .keep       (cell_keep[i])
            );
        end
    endgenerate

    assign busy   = (state_reg == ST_DRAIN);
    assign strobe = (state_reg == ST_DRAIN);

    assign result.index      = cell_entry[0].index;
    assign result.sorted_key = 32'(cell_entry[0].key);
    assign result.end_of_run = (fill_count_reg == CNT_W'(1));
    assign result.overflow   = overflow_reg;

endmodule

// File: hw/rtl/ikd_checker.sv
// ----------------------------------------------------------------------------
// ikd_checker
// Port-level checks on the descending key index sorter.
// ----------------------------------------------------------------------------
module ikd_checker
    import ikd_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input in_item_t  item,
    input logic      busy,
    input logic      strobe,
    input out_item_t result
);

    // a last key always yields at least one result right away
    a_last_starts_output: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && item.last |=> strobe)
        else $error("last key did not start output");

    // output run is contiguous until end_of_run
    a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.end_of_run |=> strobe)
        else $error("gap in output run");

    // block is free again after the final result
    a_idle_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.end_of_run |=> !busy)
        else $error("busy after end of run");

    // keys come out in non-increasing order
    a_descending: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.end_of_run |=>
            (result.sorted_key <= $past(result.sorted_key)))
        else $error("keys not descending");

    // overflow flag is constant over a run
    a_overflow_steady: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.end_of_run |=> $stable(result.overflow))
        else $error("overflow changed within run");

endmodule

bind index_sort_by_key_descending ikd_checker u_ikd_checker (.*);
